[hw/rtl/tse_pkg.sv]
// Shared types and constants for the tab stop expander.
package tse_pkg;

  localparam int unsigned CharW      = 8;
  localparam int unsigned ColW       = 16;
  localparam int unsigned StopW      = 6;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned CountW     = 3;
  localparam int unsigned RunW       = 6;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 6;
  localparam int unsigned NumStopsDefault = 6;
  localparam int unsigned DefaultStep = 8;

  localparam logic [CharW-1:0] TabByte   = 8'd9;
  localparam logic [CharW-1:0] NlByte    = 8'd10;
  localparam logic [CharW-1:0] SpaceByte = 8'd32;
  localparam logic [ColW-1:0]  ColMax    = {ColW{1'b1}};

  localparam logic [CfgIdxW-1:0] RegStopCount = 3'd0;

  typedef enum logic [1:0] {
    StIdle,
    StSkip,
    StEmit
  } state_e;

  typedef struct packed {
    logic pass_char;
    logic skip_step;
    logic load_run;
    logic emit_space;
  } cmd_t;

  typedef struct packed {
    logic is_tab;
    logic skip_more;
    logic run_last;
    logic out_free;
  } stat_t;

endpackage

[hw/rtl/tse_if.sv]
// Valid/ready channel interfaces for input bytes and output bytes.
interface tse_in_if;
  logic                        valid;
  logic                        ready;
  logic [tse_pkg::CharW-1:0]   char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface tse_out_if;
  logic                        valid;
  logic                        ready;
  logic [tse_pkg::CharW-1:0]   char_out;
  logic                        last_of_run;

  modport source (output valid, output char_out, output last_of_run, input ready);
  modport sink (input valid, input char_out, input last_of_run, output ready);
endinterface

[hw/rtl/tse_ctrl.sv]
// Control state machine: byte pass-through, tab stop skipping and space emission.
module tse_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tse_pkg::stat_t stat_i,
  output tse_pkg::cmd_t  cmd_o
);

  tse_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tse_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tse_pkg::StIdle: begin
        if (in_valid_i && stat_i.out_free && stat_i.is_tab) begin
          state_d = tse_pkg::StSkip;
        end
      end
      tse_pkg::StSkip: begin
        if (!stat_i.skip_more) begin
          state_d = tse_pkg::StEmit;
        end
      end
      tse_pkg::StEmit: begin
        if (stat_i.out_free && stat_i.run_last) begin
          state_d = tse_pkg::StIdle;
        end
      end
      default: state_d = tse_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tse_pkg::StIdle: begin
        in_ready_o      = stat_i.out_free;
        cmd_o.pass_char = in_valid_i && stat_i.out_free && !stat_i.is_tab;
      end
      tse_pkg::StSkip: begin
        cmd_o.skip_step = stat_i.skip_more;
        cmd_o.load_run  = !stat_i.skip_more;
      end
      tse_pkg::StEmit: begin
        cmd_o.emit_space = stat_i.out_free;
      end
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

[hw/rtl/tse_dp.sv]
// Datapath: stop list, column and stop index, run counter and output register.
module tse_dp #(
  parameter int unsigned NumStops = tse_pkg::NumStopsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tse_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tse_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [tse_pkg::CharW-1:0]     char_in_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [tse_pkg::CharW-1:0]     char_out_o,
  output logic                          last_of_run_o,
  input  tse_pkg::cmd_t                 cmd_i,
  output tse_pkg::stat_t                stat_o
);

  localparam int unsigned SlotW = (NumStops > 1) ? $clog2(NumStops) : 1;
  localparam logic [tse_pkg::CountW-1:0] CountLim = tse_pkg::CountW'(NumStops);
  localparam logic [tse_pkg::RunW-1:0] StepVal = tse_pkg::RunW'(tse_pkg::DefaultStep);

  logic [tse_pkg::StopW-1:0]  stop_q [NumStops];
  logic [tse_pkg::CountW-1:0] count_q;
  logic [tse_pkg::ColW-1:0]   column_q, column_d;
  logic [tse_pkg::IdxW-1:0]   idx_q, idx_d;
  logic [tse_pkg::RunW-1:0]   run_q, run_d;
  logic                       out_valid_q, out_valid_d;
  logic [tse_pkg::CharW-1:0]  char_q, char_d;
  logic                       last_q, last_d;

  logic [tse_pkg::CountW-1:0] active_cnt;
  logic                       in_list;
  logic [tse_pkg::StopW-1:0]  cur_stop;
  logic                       out_free;
  logic [tse_pkg::ColW-1:0]   column_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int k = 0; k < NumStops; k++) begin
        stop_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == tse_pkg::RegStopCount) begin
        count_q <= cfg_data_i[tse_pkg::CountW-1:0];
      end else begin
        for (int k = 0; k < NumStops; k++) begin
          if (cfg_idx_i == tse_pkg::CfgIdxW'(k + 1)) begin
            stop_q[k] <= cfg_data_i;
          end
        end
      end
    end
  end

  assign active_cnt = (count_q > CountLim) ? CountLim : count_q;
  assign in_list    = idx_q < active_cnt;
  assign cur_stop   = in_list ? stop_q[idx_q[SlotW-1:0]] : '0;
  assign out_free   = !out_valid_q || out_ready_i;
  assign column_inc = (column_q == tse_pkg::ColMax) ? column_q : column_q + 1'b1;

  assign stat_o.is_tab    = char_in_i == tse_pkg::TabByte;
  assign stat_o.skip_more = in_list &&
                            ({{(tse_pkg::ColW-tse_pkg::StopW){1'b0}}, cur_stop} <= column_q);
  assign stat_o.run_last  = run_q == tse_pkg::RunW'(1);
  assign stat_o.out_free  = out_free;

  always_comb begin
    column_d    = column_q;
    idx_d       = idx_q;
    run_d       = run_q;
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    last_d      = last_q;
    if (cmd_i.pass_char) begin
      out_valid_d = 1'b1;
      char_d      = char_in_i;
      last_d      = 1'b1;
      if (char_in_i == tse_pkg::NlByte) begin
        column_d = '0;
        idx_d    = '0;
      end else begin
        column_d = column_inc;
      end
    end
    if (cmd_i.skip_step) begin
      idx_d = idx_q + 1'b1;
    end
    if (cmd_i.load_run) begin
      if (in_list) begin
        run_d = cur_stop - column_q[tse_pkg::StopW-1:0];
        idx_d = idx_q + 1'b1;
      end else begin
        run_d = StepVal - {{(tse_pkg::RunW-3){1'b0}}, column_q[2:0]};
      end
    end
    if (cmd_i.emit_space) begin
      out_valid_d = 1'b1;
      char_d      = tse_pkg::SpaceByte;
      last_d      = run_q == tse_pkg::RunW'(1);
      run_d       = run_q - 1'b1;
      column_d    = column_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      idx_q       <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      column_q    <= column_d;
      idx_q       <= idx_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign char_out_o    = char_q;
  assign last_of_run_o = last_q;

endmodule

[hw/rtl/tab_stop_expander_core.sv]
// Top level of the tab stop expander: controller, datapath and channel wiring.
//
// Usage: text bytes enter on in_chan, one beat per byte, and leave on out_chan.
// Each output beat carries a byte and last_of_run, which is set on the final
// beat that an input byte causes. An ordinary byte or a newline gives one
// output beat, in the cycle after it is taken; the block can take such a byte
// every cycle while out_chan keeps up. A tab first walks the stop list one
// entry per cycle to pass stops at or below the current column, then sets
// up the run and emits its spaces one per cycle while out_chan keeps up,
// from 1 to 63 of them; in_chan is not ready during that time.
// The user must write the stop list and count on the cfg port only while
// the block is idle; the block itself does not enforce this. Index 0 is
// the stop count, indexes 1 to NumStops (6 by default) are the stops.
// Reset clears column, stop index, configuration and the output valid flag.
// When out_chan stalls, the output register holds its beat and no new byte
// or space is produced until it drains.
module tab_stop_expander_core #(
  parameter int unsigned NumStops = tse_pkg::NumStopsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tse_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tse_pkg::CfgDataW-1:0]  cfg_data_i,
  tse_in_if.sink                        in_chan,
  tse_out_if.source                     out_chan
);

  tse_pkg::cmd_t  cmd;
  tse_pkg::stat_t stat;

  tse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .in_ready_o (in_chan.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tse_dp #(
    .NumStops (NumStops)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .char_in_i     (in_chan.char_in),
    .out_ready_i   (out_chan.ready),
    .out_valid_o   (out_chan.valid),
    .char_out_o    (out_chan.char_out),
    .last_of_run_o (out_chan.last_of_run),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule

[sim/tab_stop_expander_core_test.sv]
// Self-checking testbench for the tab stop expander: directed table and random phases.
`timescale 1ns / 1ps

module tab_stop_expander_core_test;

  localparam int unsigned NumStops = tse_pkg::NumStopsDefault;

  localparam logic [tse_pkg::CfgIdxW-1:0] RegStopA  = 3'd1;
  localparam logic [tse_pkg::CfgIdxW-1:0] RegStopB  = 3'd2;
  localparam logic [tse_pkg::CfgIdxW-1:0] RegStopC  = 3'd3;
  localparam logic [tse_pkg::CfgIdxW-1:0] RegStopD  = 3'd4;
  localparam logic [tse_pkg::CfgIdxW-1:0] RegStopE  = 3'd5;
  localparam logic [tse_pkg::CfgIdxW-1:0] RegStopF  = 3'd6;
  localparam logic [tse_pkg::CfgIdxW-1:0] RegUnused = 3'd7;

  typedef enum logic [2:0] {
    CfgDefaultOnly,
    CfgAllHigh,
    CfgAscending,
    CfgOverCount,
    CfgAnyBits,
    CfgAllZero
  } stop_setup_e;

  typedef struct packed {
    logic [tse_pkg::CharW-1:0] char_out;
    logic                      last_of_run;
  } text_beat_t;

  typedef struct packed {
    logic                        is_write;
    logic [tse_pkg::CfgIdxW-1:0] reg_idx;
    logic [tse_pkg::CharW-1:0]   value;
    logic                        typed;
    logic [tse_pkg::RunW:0]      typed_beats;
    logic [tse_pkg::CharW-1:0]   typed_char;
  } plan_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [tse_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [tse_pkg::CfgDataW-1:0] cfg_data_i;

  tse_in_if  in_chan ();
  tse_out_if out_chan ();

  tab_stop_expander_core #(
    .NumStops(NumStops)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  always #10 clk_i = ~clk_i;

  logic [tse_pkg::CountW-1:0] stop_count_q;
  logic [tse_pkg::StopW-1:0]  stop_col_q [tse_pkg::NumStopsDefault];
  int unsigned                column_q;
  int unsigned                stop_idx_q;

  text_beat_t  run_beats [$];
  text_beat_t  out_beats_due [$];
  int unsigned mismatch_cnt;
  bit          src_gaps;
  bit          sink_gaps;

  plan_row_t plan_rows [30] = '{
    '{1'b0, '0, 8'd65,  1'b1, 7'd1, 8'd65},
    '{1'b0, '0, 8'd0,   1'b1, 7'd1, 8'd0},
    '{1'b0, '0, 8'd255, 1'b1, 7'd1, 8'd255},
    '{1'b0, '0, tse_pkg::TabByte, 1'b1, 7'd5, tse_pkg::SpaceByte},
    '{1'b0, '0, tse_pkg::TabByte, 1'b1, 7'd8, tse_pkg::SpaceByte},
    '{1'b0, '0, tse_pkg::NlByte,  1'b1, 7'd1, tse_pkg::NlByte},
    '{1'b0, '0, tse_pkg::TabByte, 1'b1, 7'd8, tse_pkg::SpaceByte},
    '{1'b0, '0, tse_pkg::NlByte,  1'b1, 7'd1, tse_pkg::NlByte},
    '{1'b1, tse_pkg::RegStopCount, 8'd3,  1'b0, 7'd0, 8'd0},
    '{1'b1, RegStopA,     8'd5,  1'b0, 7'd0, 8'd0},
    '{1'b1, RegStopB,     8'd5,  1'b0, 7'd0, 8'd0},
    '{1'b1, RegStopC,     8'd63, 1'b0, 7'd0, 8'd0},
    '{1'b0, '0, 8'd120,  1'b0, 7'd0, 8'd0},
    '{1'b0, '0, tse_pkg::TabByte, 1'b0, 7'd0, 8'd0},
    '{1'b0, '0, tse_pkg::TabByte, 1'b0, 7'd0, 8'd0},
    '{1'b0, '0, tse_pkg::TabByte, 1'b0, 7'd0, 8'd0},
    '{1'b0, '0, tse_pkg::NlByte,  1'b0, 7'd0, 8'd0},
    '{1'b0, '0, tse_pkg::TabByte, 1'b0, 7'd0, 8'd0},
    '{1'b1, tse_pkg::RegStopCount, 8'd7,  1'b0, 7'd0, 8'd0},
    '{1'b1, RegStopD,     8'd0,  1'b0, 7'd0, 8'd0},
    '{1'b1, RegStopE,     8'd63, 1'b0, 7'd0, 8'd0},
    '{1'b1, RegStopF,     8'd1,  1'b0, 7'd0, 8'd0},
    '{1'b1, RegUnused,    8'd42, 1'b0, 7'd0, 8'd0},
    '{1'b0, '0, tse_pkg::NlByte,  1'b0, 7'd0, 8'd0},
    '{1'b0, '0, tse_pkg::TabByte, 1'b0, 7'd0, 8'd0},
    '{1'b0, '0, tse_pkg::TabByte, 1'b0, 7'd0, 8'd0},
    '{1'b0, '0, tse_pkg::TabByte, 1'b0, 7'd0, 8'd0},
    '{1'b0, '0, 8'd122,  1'b0, 7'd0, 8'd0},
    '{1'b0, '0, tse_pkg::TabByte, 1'b0, 7'd0, 8'd0},
    '{1'b0, '0, tse_pkg::NlByte,  1'b0, 7'd0, 8'd0}
  };

  task automatic expand_byte(input logic [tse_pkg::CharW-1:0] ch);
    int unsigned live_stops;
    int unsigned target;
    int unsigned n_spaces;
    int unsigned k;
    run_beats.delete();
    if (ch == tse_pkg::TabByte) begin
      live_stops = (stop_count_q > NumStops) ? NumStops : stop_count_q;
      while (stop_idx_q < live_stops && stop_col_q[stop_idx_q] <= column_q) stop_idx_q++;
      if (stop_idx_q < live_stops) begin
        target = stop_col_q[stop_idx_q];
      end else begin
        target = (column_q / tse_pkg::DefaultStep + 1) * tse_pkg::DefaultStep;
      end
      n_spaces = target - column_q;
      for (k = 0; k < n_spaces; k++) begin
        run_beats.push_back('{char_out: tse_pkg::SpaceByte, last_of_run: (k + 1 == n_spaces)});
      end
      column_q = (target > tse_pkg::ColMax) ? tse_pkg::ColMax : target;
      if (stop_idx_q < live_stops) stop_idx_q++;
    end else begin
      run_beats.push_back('{char_out: ch, last_of_run: 1'b1});
      if (ch == tse_pkg::NlByte) begin
        column_q   = 0;
        stop_idx_q = 0;
      end else if (column_q < tse_pkg::ColMax) begin
        column_q++;
      end
    end
  endtask

  task automatic send_byte(input logic [tse_pkg::CharW-1:0] ch, input bit typed = 1'b0,
                           input int unsigned n_typed = 0,
                           input logic [tse_pkg::CharW-1:0] ch_typed = '0);
    int unsigned gap;
    int unsigned k;
    gap = src_gaps ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_chan.valid   <= 1'b1;
    in_chan.char_in <= ch;
    do @(posedge clk_i); while (!in_chan.ready);
    expand_byte(ch);
    if (typed) begin
      run_beats.delete();
      for (k = 0; k < n_typed; k++) begin
        run_beats.push_back('{char_out: ch_typed, last_of_run: (k + 1 == n_typed)});
      end
    end
    foreach (run_beats[i]) out_beats_due.push_back(run_beats[i]);
  endtask

  task automatic write_reg(input logic [tse_pkg::CfgIdxW-1:0] idx,
                           input logic [tse_pkg::CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == tse_pkg::RegStopCount) begin
      stop_count_q = data[tse_pkg::CountW-1:0];
    end else if (idx != RegUnused) begin
      stop_col_q[idx - RegStopA] = data;
    end
  endtask

  task automatic program_stops(input stop_setup_e setup);
    logic [tse_pkg::CfgDataW-1:0] count_val;
    logic [tse_pkg::StopW-1:0]    stop_val;
    int unsigned                  acc;
    int unsigned                  k;
    case (setup)
      CfgDefaultOnly: count_val = '0;
      CfgOverCount:   count_val = tse_pkg::CfgDataW'($urandom_range(0, 63)) | 6'd7;
      CfgAnyBits:     count_val = tse_pkg::CfgDataW'($urandom_range(0, 63));
      default:        count_val = tse_pkg::CfgDataW'(NumStops);
    endcase
    write_reg(tse_pkg::RegStopCount, count_val);
    acc = 0;
    for (k = 0; k < tse_pkg::NumStopsDefault; k++) begin
      case (setup)
        CfgAllHigh: stop_val = '1;
        CfgAllZero: stop_val = '0;
        CfgAscending: begin
          acc += $urandom_range(1, 10);
          stop_val = (acc > 63) ? 6'd63 : tse_pkg::StopW'(acc);
        end
        default: stop_val = tse_pkg::StopW'($urandom_range(0, 63));
      endcase
      write_reg(tse_pkg::CfgIdxW'(RegStopA + k), stop_val);
    end
    if ($urandom_range(0, 1) == 1) begin
      write_reg(RegUnused, tse_pkg::CfgDataW'($urandom_range(0, 63)));
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain_output();
    in_chan.valid <= 1'b0;
    while (out_beats_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned gap;
    text_beat_t  want;
    out_chan.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = sink_gaps ? $urandom_range(0, 16) : 0;
      if (gap != 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk_i); while (!out_chan.valid);
      if (out_beats_due.size() == 0) begin
        $error("unexpected beat: char_out %0d, last_of_run %0d",
               out_chan.char_out, out_chan.last_of_run);
        mismatch_cnt++;
      end else begin
        want = out_beats_due.pop_front();
        if (out_chan.char_out !== want.char_out) begin
          $error("char_out: expected %0d, actual %0d", want.char_out, out_chan.char_out);
          mismatch_cnt++;
        end
        if (out_chan.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0d, actual %0d",
                 want.last_of_run, out_chan.last_of_run);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    bit                        writing;
    int unsigned               pick;
    int                        p;
    logic [tse_pkg::CharW-1:0] ch;

    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= '0;
    cfg_data_i      <= '0;
    in_chan.valid   <= 1'b0;
    in_chan.char_in <= '0;
    stop_count_q = '0;
    foreach (stop_col_q[i]) stop_col_q[i] = '0;
    column_q     = 0;
    stop_idx_q   = 0;
    mismatch_cnt = 0;
    src_gaps     = 1'b1;
    sink_gaps    = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    writing = 1'b0;
    foreach (plan_rows[r]) begin
      if (plan_rows[r].is_write) begin
        if (!writing) drain_output();
        writing = 1'b1;
        write_reg(plan_rows[r].reg_idx, plan_rows[r].value[tse_pkg::CfgDataW-1:0]);
      end else begin
        if (writing) cfg_we_i <= 1'b0;
        writing = 1'b0;
        send_byte(plan_rows[r].value, plan_rows[r].typed, plan_rows[r].typed_beats,
                  plan_rows[r].typed_char);
      end
    end

    for (p = 0; p < 6; p++) begin
      drain_output();
      program_stops(stop_setup_e'(p));
      src_gaps  = ((p + 1) & 1) != 0;
      sink_gaps = ((p + 1) & 2) != 0;
      repeat (72) begin
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
          ch = tse_pkg::TabByte;
        end else if (pick < 46) begin
          ch = tse_pkg::NlByte;
        end else begin
          ch = tse_pkg::CharW'($urandom_range(0, 255));
        end
        send_byte(ch);
      end
    end

    drain_output();
    repeat (80) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[tab_stop_expander_core] OK");
    end else begin
      $display("[tab_stop_expander_core] ERROR");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("[tab_stop_expander_core] ERROR");
    $finish;
  end

endmodule

[files.f]
hw/rtl/tse_pkg.sv
hw/rtl/tse_if.sv
hw/rtl/tse_ctrl.sv
hw/rtl/tse_dp.sv
hw/rtl/tab_stop_expander_core.sv
sim/tab_stop_expander_core_test.sv
